### rtl/dcrc_pkg.sv
// ============================================================================
// Driver card record classifier package
// Shared types, constants and the license character test.
// ============================================================================
`default_nettype none

package dcrc_pkg;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_A    = 2'd1,
        KIND_B    = 2'd2
    } t_kind;

    // Fixed layout constants.
    localparam logic [7:0] A_START     = 8'd32;
    localparam logic [7:0] NAME_MAX    = 8'd20;
    localparam logic [7:0] YEAR_MAX    = 8'h99;
    localparam logic [7:0] MONTH_MIN   = 8'h01;
    localparam logic [7:0] MONTH_MAX   = 8'h12;
    localparam logic [7:0] DAY_MIN     = 8'h01;
    localparam logic [7:0] DAY_MAX     = 8'h31;
    localparam logic [6:0] POS_MAX     = 7'd127;
    localparam logic [7:0] NAME_LEN_IX = 8'd1;

    // One classification result.
    typedef struct packed {
        t_kind       card_kind;
        logic [5:0]  license_offset;
        logic [4:0]  name_length;
        logic [23:0] expiry_date;
    } t_result;

    // A license character is a digit, x, X, space or NUL.
    function automatic logic is_license_char(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h78) || (c == 8'h58) ||
               (c == 8'h20) || (c == 8'h00);
    endfunction

endpackage

`default_nettype wire

### rtl/dcrc_in_if.sv
// ============================================================================
// Card byte channel
// Valid/ready channel carrying one card image byte and the final-byte flag.
// ============================================================================
`default_nettype none

interface dcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] card_byte;
    logic       last_byte;

    modport source (output valid, output card_byte, output last_byte, input ready);
    modport sink   (input valid, input card_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/dcrc_out_if.sv
// ============================================================================
// Classification result channel
// Valid/ready channel carrying one classification result.
// ============================================================================
`default_nettype none

interface dcrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  card_kind;
    logic [5:0]  license_offset;
    logic [4:0]  name_length;
    logic [23:0] expiry_date;

    modport source (output valid, output card_kind, output license_offset,
                    output name_length, output expiry_date, input ready);
    modport sink   (input valid, input card_kind, input license_offset,
                    input name_length, input expiry_date, output ready);
endinterface

`default_nettype wire

### rtl/driver_card_record_classifier.sv
// ============================================================================
// Driver card record classifier
// Scans a card image byte by byte and reports which record layout it holds.
// ============================================================================
//
//  Channel    Modport   Payload                                   Per request
//  i_card     sink      card_byte[7:0], last_byte                 one image byte
//  o_result   source    card_kind[1:0], license_offset[5:0],      one verdict
//                       name_length[4:0], expiry_date[23:0]
//
//  One byte is accepted per clock cycle. The checks for a byte run in the
//  cycle that it is accepted, so the verdict for an image sits in the result
//  register in the cycle after its final byte. Only that result register can
//  stall the input: i_card.ready drops while a result waits and the sink
//  holds o_result.ready low. Synchronous active-low reset clears the scan
//  state and the result valid flag; the next byte after reset is byte zero.
//
`default_nettype none

module driver_card_record_classifier
    import dcrc_pkg::*;
#(
    parameter int IMAGE_BYTES   = 128,
    parameter int LICENSE_CHARS = 18
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dcrc_in_if.sink     i_card,
    dcrc_out_if.source  o_result
);

    logic    accept;
    logic    can_take;
    logic    res_valid;
    t_result scan_result;
    t_result res_data;

    // A byte is taken whenever the result register has room for a verdict.
    assign i_card.ready = can_take;
    assign accept       = i_card.valid && can_take;

    // Per-byte checks and the verdict for the final byte.
    dcrc_scan #(
        .IMAGE_BYTES   (IMAGE_BYTES),
        .LICENSE_CHARS (LICENSE_CHARS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_card_byte (i_card.card_byte),
        .i_last_byte (i_card.last_byte),
        .o_result    (scan_result)
    );

    // Result register between the scanner and the downstream side.
    dcrc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && i_card.last_byte),
        .i_result   (scan_result),
        .i_ready    (o_result.ready),
        .o_valid    (res_valid),
        .o_result   (res_data),
        .o_can_take (can_take)
    );

    assign o_result.valid          = res_valid;
    assign o_result.card_kind      = res_data.card_kind;
    assign o_result.license_offset = res_data.license_offset;
    assign o_result.name_length    = res_data.name_length;
    assign o_result.expiry_date    = res_data.expiry_date;

endmodule

`default_nettype wire

### rtl/dcrc_scan.sv
// ============================================================================
// Card byte scanner
// Tracks the byte position and the layout checks; forms the result on the
// final byte.
// ============================================================================
`default_nettype none

module dcrc_scan
    import dcrc_pkg::*;
#(
    parameter int IMAGE_BYTES   = 128,
    parameter int LICENSE_CHARS = 18
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_card_byte,
    input  wire logic       i_last_byte,
    output t_result         o_result
);

    localparam logic [7:0] IMAGE_END = 8'(IMAGE_BYTES);
    localparam logic [7:0] LIC_LEN   = 8'(LICENSE_CHARS);
    localparam logic [7:0] A_DATE    = A_START + LIC_LEN;
    localparam logic [7:0] A_END     = A_DATE + 8'd2;

    logic [6:0]  r_byte_position, n_byte_position;
    logic        r_layout_a_ok, n_layout_a_ok;
    logic        r_layout_b_ok, n_layout_b_ok;
    logic [4:0]  r_prefix_length, n_prefix_length;
    logic [23:0] r_date_bytes, n_date_bytes;

    logic [7:0] idx;
    logic [7:0] b_lo;
    logic [7:0] b_hi;
    logic [7:0] b_end;
    logic [7:0] arrived;
    logic       lic_ok;
    logic       a_ok;
    logic       b_ok;

    always_comb begin
        idx             = {1'b0, r_byte_position};
        lic_ok          = is_license_char(i_card_byte);
        b_lo            = 8'd2 + {3'b000, r_prefix_length};
        b_hi            = b_lo + LIC_LEN;
        n_layout_a_ok   = r_layout_a_ok;
        n_layout_b_ok   = r_layout_b_ok;
        n_prefix_length = r_prefix_length;
        n_date_bytes    = r_date_bytes;

        if (idx < IMAGE_END) begin
            if ((idx >= A_START) && (idx < A_DATE)) begin
                if (!lic_ok) n_layout_a_ok = 1'b0;
            end else if (idx == A_DATE) begin
                if (i_card_byte > YEAR_MAX) n_layout_a_ok = 1'b0;
                n_date_bytes = {r_date_bytes[15:0], i_card_byte};
            end else if (idx == A_DATE + 8'd1) begin
                if ((i_card_byte < MONTH_MIN) || (i_card_byte > MONTH_MAX)) begin
                    n_layout_a_ok = 1'b0;
                end
                n_date_bytes = {r_date_bytes[15:0], i_card_byte};
            end else if (idx == A_END) begin
                if ((i_card_byte < DAY_MIN) || (i_card_byte > DAY_MAX)) begin
                    n_layout_a_ok = 1'b0;
                end
                n_date_bytes = {r_date_bytes[15:0], i_card_byte};
            end

            if (idx == NAME_LEN_IX) begin
                if (i_card_byte > NAME_MAX) n_layout_b_ok = 1'b0;
                else n_prefix_length = i_card_byte[4:0];
            end else if ((idx >= b_lo) && (idx < b_hi)) begin
                if (!lic_ok) n_layout_b_ok = 1'b0;
            end
        end

        n_byte_position = (r_byte_position < POS_MAX) ? r_byte_position + 7'd1
                                                      : r_byte_position;

        // Verdict on the final byte, using the state as updated by it.
        arrived = idx + 8'd1;
        b_end   = 8'd1 + {3'b000, n_prefix_length} + LIC_LEN;
        a_ok    = n_layout_a_ok && (A_END < arrived) && (A_END < IMAGE_END);
        b_ok    = n_layout_b_ok && (b_end < arrived) && (b_end < IMAGE_END);

        o_result = '0;
        if (a_ok) begin
            o_result.card_kind      = KIND_A;
            o_result.license_offset = A_START[5:0];
            o_result.expiry_date    = n_date_bytes;
        end else if (b_ok) begin
            o_result.card_kind      = KIND_B;
            o_result.license_offset = 6'd2 + {1'b0, n_prefix_length};
            o_result.name_length    = n_prefix_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_layout_a_ok   <= 1'b1;
            r_layout_b_ok   <= 1'b1;
            r_prefix_length <= '0;
            r_date_bytes    <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_byte_position <= '0;
                r_layout_a_ok   <= 1'b1;
                r_layout_b_ok   <= 1'b1;
                r_prefix_length <= '0;
                r_date_bytes    <= '0;
            end else begin
                r_byte_position <= n_byte_position;
                r_layout_a_ok   <= n_layout_a_ok;
                r_layout_b_ok   <= n_layout_b_ok;
                r_prefix_length <= n_prefix_length;
                r_date_bytes    <= n_date_bytes;
            end
        end
    end

    // The final byte always rearms the scanner for the next image.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=>
            (r_byte_position == 7'd0) && r_layout_a_ok && r_layout_b_ok)
        else $error("scanner not rearmed after final byte");

    // The position advances by one per byte until it saturates.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last_byte && (r_byte_position < POS_MAX)) |=>
            (r_byte_position == $past(r_byte_position) + 7'd1))
        else $error("byte position did not advance");

    // A stored name length never exceeds the layout B limit.
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({3'b000, r_prefix_length} <= NAME_MAX))
        else $error("name length out of range");

endmodule

`default_nettype wire

### rtl/dcrc_out.sv
// ============================================================================
// Result register
// Holds one result until the downstream side takes it.
// ============================================================================
`default_nettype none

module dcrc_out
    import dcrc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_result  i_result,
    input  wire logic     i_ready,
    output logic          o_valid,
    output t_result       o_result,
    output logic          o_can_take
);

    logic    r_valid;
    t_result r_result;

    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_take) begin
            r_result <= i_result;
        end
    end

    // Kind A always reports the fixed offset and no name length.
    a_kind_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_result.card_kind == KIND_A)) |->
            (r_result.license_offset == A_START[5:0]) && (r_result.name_length == 5'd0))
        else $error("kind A result malformed");

    // No valid license means an all-zero result.
    a_kind_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_result.card_kind == KIND_NONE)) |->
            (r_result.license_offset == 6'd0) && (r_result.expiry_date == 24'd0))
        else $error("kind none result not cleared");

    // A held result is not overwritten by a new final byte.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> r_valid && (r_result == $past(r_result)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
